// ----- rtl/scfa_pkg.sv -----
// Shared types, widths and helpers for the sphere contact force accumulator.
// No dependencies; every other file imports this package.
package scfa_pkg;

   localparam int POS_WIDTH  = 24;
   localparam int SUM_WIDTH  = 40;

   localparam int RAD_W      = 16;
   localparam int STIFF_W    = 20;
   localparam int SCALE_W    = 16;
   localparam int FORCE_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int T_W        = POS_WIDTH + SCALE_W + 1 - 8;
   localparam int D_W        = T_W + 1;
   localparam int RSUM_W     = RAD_W + 1;
   localparam int SQ_W       = 2 * RSUM_W;
   localparam int D2_W       = SQ_W + 2;
   localparam int RADSQ_W    = D2_W + 16;
   localparam int ROOT_W     = RADSQ_W / 2;
   localparam int SREM_W     = ROOT_W + 3;
   localparam int PEN_W      = RSUM_W + 8;
   localparam int PK_W       = PEN_W + STIFF_W;
   localparam int DVD_W      = PK_W + RSUM_W;
   localparam int QUO_W      = 48;
   localparam int DEN_W      = ROOT_W + 8;
   localparam int F_W        = QUO_W + 1;
   localparam int EXT_W      = ((SUM_WIDTH > F_W) ? SUM_WIDTH : F_W) + 1;
   localparam int QS_W       = SUM_WIDTH - 8;
   localparam int QC_W       = 42;
   localparam int PQ_W       = QC_W + SCALE_W + 1;
   localparam int CNT_W      = 6;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUO_W;

   localparam logic [RAD_W-1:0]   TOOL_RADIUS_RST = RAD_W'(6554);
   localparam logic [RAD_W-1:0]   NODE_RADIUS_RST = RAD_W'(3277);
   localparam logic [STIFF_W-1:0] STIFF_RST       = STIFF_W'(10240);
   localparam logic [SCALE_W-1:0] WSCALE_RST      = SCALE_W'(256);
   localparam logic [SCALE_W-1:0] OSCALE_RST      = SCALE_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOOL_RADIUS = 3'd0,
      CSR_NODE_RADIUS = 3'd1,
      CSR_STIFFNESS   = 3'd2,
      CSR_WS_SCALE    = 3'd3,
      CSR_OUT_SCALE   = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCALE, ST_DIFF, ST_SQUARE, ST_TEST, ST_SQRT, ST_PEN,
      ST_PROD, ST_DIV, ST_FORCE, ST_TOTMUL, ST_TOTAL, ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic scale;
      logic diff;
      logic square;
      logic test;
      logic sqrt_step;
      logic pen;
      logic prod;
      logic div_step;
      logic apply_force;
      logic tot_mul;
      logic tot_fin;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic contact;
      logic last;
      logic out_free;
   } status_type;

   // clamp a signed value to the 32 bit range
   function automatic logic signed [FORCE_W-1:0] sat32(input logic signed [63:0] v);
      logic fits;
      fits = (&v[63:FORCE_W-1]) | ~(|v[63:FORCE_W-1]);
      if (fits) sat32 = v[FORCE_W-1:0];
      else if (v[63]) sat32 = {1'b1, {(FORCE_W-1){1'b0}}};
      else sat32 = {1'b0, {(FORCE_W-1){1'b1}}};
   endfunction

endpackage

// ----- rtl/scfa_ifs.sv -----
// Channel interfaces: request, response and register write channels.
// Depends on scfa_pkg for field widths.
interface scfa_req_if import scfa_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [POS_WIDTH-1:0] tool_pos_x;
   logic signed [POS_WIDTH-1:0] tool_pos_y;
   logic signed [POS_WIDTH-1:0] tool_pos_z;
   logic signed [POS_WIDTH-1:0] node_pos_x;
   logic signed [POS_WIDTH-1:0] node_pos_y;
   logic signed [POS_WIDTH-1:0] node_pos_z;
   logic last_node;
   modport source (output valid, tool_pos_x, tool_pos_y, tool_pos_z,
                   node_pos_x, node_pos_y, node_pos_z, last_node, input ready);
   modport sink (input valid, tool_pos_x, tool_pos_y, tool_pos_z,
                 node_pos_x, node_pos_y, node_pos_z, last_node, output ready);
endinterface

interface scfa_rsp_if import scfa_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [FORCE_W-1:0] node_force_x;
   logic signed [FORCE_W-1:0] node_force_y;
   logic signed [FORCE_W-1:0] node_force_z;
   logic signed [FORCE_W-1:0] total_force_x;
   logic signed [FORCE_W-1:0] total_force_y;
   logic signed [FORCE_W-1:0] total_force_z;
   logic total_valid;
   modport source (output valid, node_force_x, node_force_y, node_force_z,
                   total_force_x, total_force_y, total_force_z, total_valid,
                   input ready);
   modport sink (input valid, node_force_x, node_force_y, node_force_z,
                 total_force_x, total_force_y, total_force_z, total_valid,
                 output ready);
endinterface

interface scfa_csr_if import scfa_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] idx;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, idx, wdata, input ready);
   modport sink (input valid, idx, wdata, output ready);
endinterface

// ----- rtl/sphere_contact_force_accumulator_core.sv -----
// Sphere contact force accumulator, top level.
// Channels: req_chan takes one word per node (raw tool position, node
//   centre, last_node flag); rsp_chan returns one word per node with the
//   reaction force on that node, and on the last node of a frame the
//   scaled frame total with total_valid set. csr_chan writes the five
//   registers by index; it is always ready and must only be used idle.
// Steps: a node out of contact skips the root and divide steps; a node
//   in contact runs 26 root steps and then 48 divide steps on three
//   parallel dividers; the last node of a frame adds the total steps.
// Flow: one node at a time; the next word is accepted the cycle
//   after the previous result is placed in the output register; for a
//   node in contact the root unit and the dividers set the pace.
// Reset: clears the sequencer, the frame sums and the output valid, and
//   loads the register defaults.
// Stall: a result waits in the output register; the block still takes and
//   computes the next node, then holds it until the register frees up.
// Depends on scfa_pkg, scfa_ifs, scfa_ctrl and scfa_dp.
module sphere_contact_force_accumulator_core import scfa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   scfa_req_if.sink  req_chan,
   scfa_rsp_if.source rsp_chan,
   scfa_csr_if.sink  csr_chan
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic signed [POS_WIDTH-1:0] tool_pos [3];
   logic signed [POS_WIDTH-1:0] node_pos [3];

   assign req_chan.ready = req_ready;
   assign tool_pos[0] = req_chan.tool_pos_x;
   assign tool_pos[1] = req_chan.tool_pos_y;
   assign tool_pos[2] = req_chan.tool_pos_z;
   assign node_pos[0] = req_chan.node_pos_x;
   assign node_pos[1] = req_chan.node_pos_y;
   assign node_pos[2] = req_chan.node_pos_z;

   // sequencer
   scfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, sums and output register
   scfa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .tool_pos  (tool_pos),
      .node_pos  (node_pos),
      .last_node (req_chan.last_node),
      .csr_chan  (csr_chan),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTH
   // an accepted word starts the scale step next cycle
   a_accept_scale: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> cmd.scale)
      else $error("accepted word did not start scaling");

   // never overwrite a result still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output register overwritten");

   // the total multiply is always followed by the sum clear
   a_total_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.tot_mul |=> cmd.tot_fin)
      else $error("frame total not finished");
`endif

endmodule

// ----- rtl/scfa_ctrl.sv -----
// Sequencer for the contact force datapath: walks one word through scale,
// distance, square root, divide and accumulate steps. Depends on scfa_pkg.
module scfa_ctrl import scfa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_TEST;
         ST_TEST:   state_in = ST_SQRT;
         ST_SQRT: begin
            if (!status.contact) state_in = ST_FORCE;
            else if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) state_in = ST_PEN;
         end
         ST_PEN:    state_in = ST_PROD;
         ST_PROD:   state_in = ST_DIV;
         ST_DIV:    if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = ST_FORCE;
         ST_FORCE:  state_in = status.last ? ST_TOTMUL : ST_OUT;
         ST_TOTMUL: state_in = ST_TOTAL;
         ST_TOTAL:  state_in = ST_OUT;
         ST_OUT:    if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // step counter for the iterative units
   always_comb begin
      cnt_in = '0;
      if ((state_ff == ST_SQRT && status.contact &&
           cnt_ff != CNT_W'(SQRT_STEPS - 1)) ||
          (state_ff == ST_DIV && cnt_ff != CNT_W'(DIV_STEPS - 1)))
         cnt_in = cnt_ff + CNT_W'(1);
   end

   // outputs
   always_comb begin
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SCALE:  cmd.scale       = 1'b1;
         ST_DIFF:   cmd.diff        = 1'b1;
         ST_SQUARE: cmd.square      = 1'b1;
         ST_TEST:   cmd.test        = 1'b1;
         ST_SQRT:   cmd.sqrt_step   = status.contact;
         ST_PEN:    cmd.pen         = 1'b1;
         ST_PROD:   cmd.prod        = 1'b1;
         ST_DIV:    cmd.div_step    = 1'b1;
         ST_FORCE:  cmd.apply_force = 1'b1;
         ST_TOTMUL: cmd.tot_mul     = 1'b1;
         ST_TOTAL:  cmd.tot_fin     = 1'b1;
         ST_OUT:    cmd.out_load    = status.out_free;
         default: ;
      endcase
   end

endmodule

// ----- rtl/scfa_dp.sv -----
// Datapath: register file, per-axis lanes, bit-serial square root, three
// restoring dividers, saturating sums and output register. Uses scfa_pkg.
module scfa_dp import scfa_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic signed [POS_WIDTH-1:0] tool_pos [3],
   input  logic signed [POS_WIDTH-1:0] node_pos [3],
   input  logic                        last_node,
   scfa_csr_if.sink                    csr_chan,
   scfa_rsp_if.source                  rsp_chan
);

   logic [RAD_W-1:0]   tool_radius_ff, node_radius_ff;
   logic [STIFF_W-1:0] stiff_ff;
   logic [SCALE_W-1:0] wscale_ff, oscale_ff;

   logic signed [POS_WIDTH-1:0] tpos_ff [3];
   logic signed [POS_WIDTH-1:0] npos_ff [3];
   logic                        last_ff;
   logic signed [T_W-1:0]       t_ff [3];
   logic                        neg_ff [3];
   logic [D_W-1:0]              mag_ff [3];
   logic [RSUM_W-1:0]           rsum_ff;
   logic [SQ_W-1:0]             sq_ff [3];
   logic [SQ_W-1:0]             rsq_ff;
   logic                        near_ff, contact_ff;
   logic [RADSQ_W-1:0]          rad_ff;
   logic [SREM_W-1:0]           srem_ff;
   logic [ROOT_W-1:0]           root_ff;
   logic [PK_W-1:0]             pk_ff;
   logic [DEN_W-1:0]            drem_ff [3];
   logic [QUO_W-1:0]            dq_ff [3];
   logic signed [FORCE_W-1:0]   nf_ff [3];
   logic signed [SUM_WIDTH-1:0] sum_ff [3];
   logic signed [PQ_W-1:0]      pq_ff [3];
   logic [15:0]                 pr_ff [3];
   logic signed [FORCE_W-1:0]   tot_ff [3];
   logic                        rsp_valid_ff;

   logic signed [POS_WIDTH+SCALE_W:0] scl [3];
   logic signed [D_W-1:0]             dif [3];
   logic [D2_W-1:0]                   d2;
   logic [SREM_W-1:0]                 srem_try, trial;
   logic [PEN_W-1:0]                  pen;
   logic [PK_W-1:0]                   pk_c;
   logic [DVD_W-1:0]                  dvd [3];
   logic [DEN_W-1:0]                  den;
   logic [DEN_W:0]                    dtry [3];
   logic signed [F_W-1:0]             fmag [3], f [3];
   logic signed [F_W:0]               negf [3];
   logic signed [EXT_W-1:0]           acc [3];
   logic signed [SUM_WIDTH-1:0]       acc_sat [3];
   logic signed [QS_W-1:0]            qs [3];
   logic signed [63:0]                q64 [3];
   logic signed [QC_W-1:0]            qc [3];
   logic [RSUM_W+SCALE_W+6:0]         rprod [3];

   // register file, always ready
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tool_radius_ff <= TOOL_RADIUS_RST;
         node_radius_ff <= NODE_RADIUS_RST;
         stiff_ff       <= STIFF_RST;
         wscale_ff      <= WSCALE_RST;
         oscale_ff      <= OSCALE_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.idx)
            CSR_TOOL_RADIUS: tool_radius_ff <= csr_chan.wdata[RAD_W-1:0];
            CSR_NODE_RADIUS: node_radius_ff <= csr_chan.wdata[RAD_W-1:0];
            CSR_STIFFNESS:   stiff_ff       <= csr_chan.wdata[STIFF_W-1:0];
            CSR_WS_SCALE:    wscale_ff      <= csr_chan.wdata[SCALE_W-1:0];
            CSR_OUT_SCALE:   oscale_ff      <= csr_chan.wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // lane arithmetic
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         scl[i]  = tpos_ff[i] * $signed({1'b0, wscale_ff});
         dif[i]  = D_W'(t_ff[i]) - D_W'(npos_ff[i]);
         dvd[i]  = DVD_W'(pk_ff) * DVD_W'(mag_ff[i][RSUM_W-1:0]);
         dtry[i] = {drem_ff[i], dq_ff[i][QUO_W-1]};
         fmag[i] = $signed({1'b0, dq_ff[i]});
         f[i]    = !contact_ff ? '0 : (neg_ff[i] ? -fmag[i] : fmag[i]);
         negf[i] = -((F_W+1)'(f[i]));
         acc[i]  = EXT_W'(sum_ff[i]) + EXT_W'(f[i]);
         if ((&acc[i][EXT_W-1:SUM_WIDTH-1]) | ~(|acc[i][EXT_W-1:SUM_WIDTH-1]))
            acc_sat[i] = acc[i][SUM_WIDTH-1:0];
         else if (acc[i][EXT_W-1])
            acc_sat[i] = {1'b1, {(SUM_WIDTH-1){1'b0}}};
         else
            acc_sat[i] = {1'b0, {(SUM_WIDTH-1){1'b1}}};
         qs[i]  = sum_ff[i][SUM_WIDTH-1:8];
         q64[i] = 64'(qs[i]);
         if (q64[i] > 64'sd1099511627776)
            qc[i] = QC_W'(64'sd1099511627776);
         else if (q64[i] < -64'sd1099511627776)
            qc[i] = QC_W'(-64'sd1099511627776);
         else
            qc[i] = q64[i][QC_W-1:0];
         rprod[i] = (RSUM_W+SCALE_W+7)'(sum_ff[i][7:0]) *
                    (RSUM_W+SCALE_W+7)'(oscale_ff);
      end
   end

   always_comb begin
      d2       = D2_W'(sq_ff[0]) + D2_W'(sq_ff[1]) + D2_W'(sq_ff[2]);
      srem_try = {srem_ff[SREM_W-3:0], rad_ff[RADSQ_W-1 -: 2]};
      trial    = SREM_W'({root_ff, 2'b01});
      pen      = {rsum_ff, 8'd0} - PEN_W'(root_ff);
      pk_c     = PK_W'(pen) * PK_W'(stiff_ff);
      den      = {root_ff, 8'd0};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < 3; i++) begin
            tpos_ff[i] <= tool_pos[i];
            npos_ff[i] <= node_pos[i];
         end
         last_ff <= last_node;
      end
      if (cmd.scale)
         for (int i = 0; i < 3; i++) t_ff[i] <= scl[i][POS_WIDTH+SCALE_W:8];
      if (cmd.diff) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= dif[i][D_W-1];
            mag_ff[i] <= dif[i][D_W-1] ? D_W'(-dif[i]) : D_W'(dif[i]);
         end
         rsum_ff <= RSUM_W'(tool_radius_ff) + RSUM_W'(node_radius_ff);
      end
      if (cmd.square) begin
         near_ff <= (mag_ff[0] <= D_W'(rsum_ff)) && (mag_ff[1] <= D_W'(rsum_ff)) &&
                    (mag_ff[2] <= D_W'(rsum_ff));
         for (int i = 0; i < 3; i++)
            sq_ff[i] <= SQ_W'(mag_ff[i][RSUM_W-1:0]) * SQ_W'(mag_ff[i][RSUM_W-1:0]);
         rsq_ff <= SQ_W'(rsum_ff) * SQ_W'(rsum_ff);
      end
      // arm the root unit: one result bit per step
      if (cmd.test) begin
         contact_ff <= near_ff && (d2 != '0) && (d2 <= D2_W'(rsq_ff));
         rad_ff     <= {d2, 16'd0};
         srem_ff    <= '0;
         root_ff    <= '0;
      end
      if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[RADSQ_W-3:0], 2'b00};
         if (srem_try >= trial) begin
            srem_ff <= srem_try - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= srem_try;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.pen) pk_ff <= pk_c;
      // load dividers; upper dividend bits are always below the divisor
      if (cmd.prod)
         for (int i = 0; i < 3; i++) begin
            drem_ff[i] <= DEN_W'(dvd[i][DVD_W-1:QUO_W]);
            dq_ff[i]   <= dvd[i][QUO_W-1:0];
         end
      if (cmd.div_step)
         for (int i = 0; i < 3; i++) begin
            if (dtry[i] >= {1'b0, den}) begin
               drem_ff[i] <= DEN_W'(dtry[i] - {1'b0, den});
               dq_ff[i]   <= {dq_ff[i][QUO_W-2:0], 1'b1};
            end else begin
               drem_ff[i] <= DEN_W'(dtry[i]);
               dq_ff[i]   <= {dq_ff[i][QUO_W-2:0], 1'b0};
            end
         end
      if (cmd.apply_force)
         for (int i = 0; i < 3; i++) nf_ff[i] <= sat32(64'(negf[i]));
      if (cmd.tot_mul)
         for (int i = 0; i < 3; i++) begin
            pq_ff[i] <= PQ_W'(qc[i]) * PQ_W'($signed({1'b0, oscale_ff}));
            pr_ff[i] <= rprod[i][23:8];
         end
      if (cmd.tot_fin)
         for (int i = 0; i < 3; i++)
            tot_ff[i] <= sat32(64'(pq_ff[i]) + 64'(pr_ff[i]));
   end

   // frame sums: accumulate, then drop after the total is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
      end else if (cmd.apply_force) begin
         for (int i = 0; i < 3; i++) sum_ff[i] <= acc_sat[i];
      end else if (cmd.tot_fin) begin
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_chan.node_force_x  <= nf_ff[0];
         rsp_chan.node_force_y  <= nf_ff[1];
         rsp_chan.node_force_z  <= nf_ff[2];
         rsp_chan.total_force_x <= last_ff ? tot_ff[0] : '0;
         rsp_chan.total_force_y <= last_ff ? tot_ff[1] : '0;
         rsp_chan.total_force_z <= last_ff ? tot_ff[2] : '0;
         rsp_chan.total_valid   <= last_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign status.contact   = contact_ff;
   assign status.last      = last_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_chan.ready;

endmodule
